@@ design/pulse_bitmap_delta_varint_encoder_assert.svh @@
// Assertion macros for the pulse bitmap delta encoder.
`ifndef PULSE_BITMAP_DELTA_VARINT_ENCODER_ASSERT_SVH
`define PULSE_BITMAP_DELTA_VARINT_ENCODER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define PBDVE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbdve check failed");

// next-cycle implication, quiet during reset
`define PBDVE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbdve check failed");

`endif

@@ design/pbdve_pkg.sv @@
// Package: constants, sequencer state type and defaults for the delta encoder.
package pbdve_pkg;

   localparam int POSITION_BITS_DEF = 28;
   localparam int WORD_BITS         = 16;
   localparam int TRACK_BITS        = 24;
   localparam int PULSE_BITS        = 28;
   localparam int BYTE_CNT_BITS     = 30;
   localparam int CELL_BITS         = 5;

   // length class limits
   localparam logic [31:0] LIM_1B = 32'h0000_0080;
   localparam logic [31:0] LIM_2B = 32'h0000_4000;
   localparam logic [31:0] LIM_3B = 32'h0020_0000;
   localparam logic [31:0] LIM_4B = 32'h1000_0000;

   localparam logic [31:0] TAG_2B   = 32'h0000_8000;
   localparam logic [31:0] TAG_3B   = 32'h00C0_0000;
   localparam logic [31:0] TAG_4B   = 32'hE000_0000;
   localparam logic [31:0] CODE_SAT = 32'hEFFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_EMIT   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

@@ design/pulse_bitmap_delta_varint_encoder.sv @@
// Top level: pulse bitmap to prefix-coded pulse distance byte stream.
// Each request carries one 16-bit bitmap word, scanned MSB first. A small sequencer
// steps through the sixteen cells one per clock, pausing while a pulse's code bytes
// are sent; for every pulse a shared subtractor forms the distance from the previous
// pulse and the code bytes are then sent one per clock, while the response side does
// not stall, through a single output register. req_stall stays high while the word
// is scanned, its code bytes are sent and the word is closed, and falls once the last
// byte of the word has been taken; a new word is only taken in the idle state, after
// the last one is done. The track length register is written through the csr_ port;
// the user must write it only while idle: the block itself does not enforce this.
module pulse_bitmap_delta_varint_encoder
   import pbdve_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [WORD_BITS-1:0]      req_bitmap_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_code_byte,
   output logic                      rsp_code_start,
   output logic                      rsp_item_last,
   output logic [PULSE_BITS-1:0]     rsp_pulse_number,
   output logic [BYTE_CNT_BITS-1:0]  rsp_byte_index,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [TRACK_BITS-1:0]     csr_track_words
);

   state_type                state_ff, state_in;
   logic [TRACK_BITS-1:0]    track_words_ff;
   logic [TRACK_BITS-1:0]    word_pos_ff;
   logic [POSITION_BITS-1:0] last_pos_ff;
   logic [PULSE_BITS-1:0]    pulse_ff;
   logic [BYTE_CNT_BITS-1:0] byte_ff;
   logic [WORD_BITS-1:0]     word_ff;
   logic [CELL_BITS-1:0]     cell_ff;
   logic [POSITION_BITS-1:0] dist_ff;
   logic [1:0]               sent_ff;

   logic                     rsp_valid_ff;
   logic [7:0]               rsp_byte_ff;
   logic                     rsp_start_ff;
   logic                     rsp_last_ff;
   logic [PULSE_BITS-1:0]    rsp_pulse_ff;
   logic [BYTE_CNT_BITS-1:0] rsp_index_ff;

   logic [27:0]              pos_full;
   logic [POSITION_BITS-1:0] pos;
   logic [POSITION_BITS-1:0] dist_in;
   logic [1:0]               code_len;
   logic [7:0]               code_byte;
   logic                     out_free;
   logic                     req_take;
   logic                     track_end;

   pbdve_fmt #(
      .POSITION_BITS (POSITION_BITS)
   ) u_fmt (
      .gap       (dist_ff),
      .sent      (sent_ff),
      .len       (code_len),
      .code_byte (code_byte)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign pos_full = {word_pos_ff, cell_ff[3:0]};
   assign pos      = POSITION_BITS'(pos_full);
   // shared subtractor, wraps at the position width
   assign dist_in  = pos - last_pos_ff;

   assign track_end = ({1'b0, word_pos_ff} + 25'd1) >= {1'b0, track_words_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (cell_ff[CELL_BITS-1]) state_in = ST_FINISH;
            else if (word_ff[WORD_BITS-1]) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && sent_ff == code_len) state_in = ST_SCAN;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         track_words_ff <= TRACK_BITS'(1);
         word_pos_ff    <= '0;
         last_pos_ff    <= '0;
         pulse_ff       <= '0;
         byte_ff        <= '0;
         cell_ff        <= '0;
         sent_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) track_words_ff <= csr_track_words;

         if (state_ff == ST_EMIT && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  word_ff <= req_bitmap_word;
                  cell_ff <= '0;
               end
            end
            ST_SCAN: begin
               if (!cell_ff[CELL_BITS-1]) begin
                  word_ff <= word_ff << 1;
                  cell_ff <= cell_ff + CELL_BITS'(1);
                  if (word_ff[WORD_BITS-1]) begin
                     dist_ff     <= dist_in;
                     last_pos_ff <= pos;
                     pulse_ff    <= pulse_ff + PULSE_BITS'(1);
                     sent_ff     <= '0;
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_byte_ff  <= code_byte;
                  rsp_start_ff <= (sent_ff == 2'd0);
                  // word_ff already shifted past this pulse
                  rsp_last_ff  <= (sent_ff == code_len) && (word_ff == '0);
                  rsp_pulse_ff <= pulse_ff;
                  rsp_index_ff <= byte_ff;
                  byte_ff      <= byte_ff + BYTE_CNT_BITS'(1);
                  sent_ff      <= sent_ff + 2'd1;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff) begin
                  if (track_end) begin
                     word_pos_ff <= '0;
                     last_pos_ff <= '0;
                     pulse_ff    <= '0;
                     byte_ff     <= '0;
                  end else begin
                     word_pos_ff <= word_pos_ff + TRACK_BITS'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code_byte    = rsp_byte_ff;
   assign rsp_code_start   = rsp_start_ff;
   assign rsp_item_last    = rsp_last_ff;
   assign rsp_pulse_number = rsp_pulse_ff;
   assign rsp_byte_index   = rsp_index_ff;

endmodule

@@ design/pbdve_fmt.sv @@
// Prefix code formatter: length class and the selected byte of one distance.
module pbdve_fmt
   import pbdve_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic [POSITION_BITS-1:0] gap,
   input  logic [1:0]               sent,
   output logic [1:0]               len,
   output logic [7:0]               code_byte
);

   logic [31:0] dist_w;
   logic [31:0] code_w;
   logic [1:0]  idx;

   assign dist_w = 32'(gap);

   always_comb begin
      if (dist_w < LIM_1B) begin
         len    = 2'd0;
         code_w = dist_w;
      end else if (dist_w < LIM_2B) begin
         len    = 2'd1;
         code_w = TAG_2B | dist_w;
      end else if (dist_w < LIM_3B) begin
         len    = 2'd2;
         code_w = TAG_3B | dist_w;
      end else if (dist_w < LIM_4B) begin
         len    = 2'd3;
         code_w = TAG_4B | dist_w;
      end else begin
         len    = 2'd3;
         code_w = CODE_SAT;
      end
   end

   // bytes go out most significant first
   assign idx = len - sent;

   always_comb begin
      case (idx)
         2'd0:    code_byte = code_w[7:0];
         2'd1:    code_byte = code_w[15:8];
         2'd2:    code_byte = code_w[23:16];
         2'd3:    code_byte = code_w[31:24];
         default: code_byte = code_w[7:0];
      endcase
   end

endmodule

@@ design/pbdve_checker.sv @@
// Port-level checker for the delta encoder, bound to the top level.
`include "pulse_bitmap_delta_varint_encoder_assert.svh"

module pbdve_checker
   import pbdve_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [7:0]               rsp_code_byte,
   input logic                     rsp_code_start,
   input logic                     rsp_item_last,
   input logic [PULSE_BITS-1:0]    rsp_pulse_number,
   input logic [BYTE_CNT_BITS-1:0] rsp_byte_index
);

   // a stalled response byte holds with all its fields
   `PBDVE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_code_byte) && $stable(rsp_code_start)
      && $stable(rsp_item_last) && $stable(rsp_pulse_number)
      && $stable(rsp_byte_index))

   // ready for a new word only once every byte of the last one is gone
   `PBDVE_ASSERT_NOW(a_idle_drained, clock, reset, !req_stall, !rsp_valid)

   // no byte follows straight after the last byte of a word is taken
   `PBDVE_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && !rsp_stall && rsp_item_last, !rsp_valid)

   // a taken request keeps the block busy
   `PBDVE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

endmodule

bind pulse_bitmap_delta_varint_encoder pbdve_checker u_pbdve_checker (.*);
